// ===== rtl/core/midi_channel_mixer_defines.svh =====
// Assertion macros used by the mixer sequencer RTL.
`ifndef MIDI_CHANNEL_MIXER_DEFINES_SVH
`define MIDI_CHANNEL_MIXER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer check failed");

// Next-cycle implication, checked out of reset.
`define MCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer check failed");

`endif

// ===== rtl/core/mcm_pkg.sv =====
// Types and constants for the MIDI channel mixer.
`default_nettype none

package mcm_pkg;

    localparam int CHAN_W = 4;
    localparam int VAL_W  = 7;
    localparam int KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_FADER   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_KNOB    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SOLO    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MUTE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_VOLUME  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BALANCE = 3'd5;

    localparam logic [VAL_W-1:0] VALUE_MAX  = 7'h7f;
    localparam logic [VAL_W-1:0] VALUE_MID  = 7'h40;
    localparam logic [VAL_W-1:0] FADER_OFF  = 7'h00;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] chan_index;
        logic [VAL_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_chan;
        logic              is_balance;
        logic [VAL_W-1:0]  out_value;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic              emit;
        logic              last;
        logic              on;
        logic              self_chan;
        logic [KIND_W-1:0] op;
        logic [CHAN_W-1:0] idx;
    } mcm_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/midi_channel_mixer.sv =====
// Top level of the MIDI channel mixer.
//
// Usage: drive in_item and raise start; the item is taken at a rising edge
// with start high and busy low. Each result appears on result for exactly
// one cycle with result_valid high; the receiver cannot stall it.
// Fader, knob, mute, player volume and player balance items give one result
// after acceptance (step, weigh, present) and keep busy high through the
// sequencer's step and emit states. A solo item steps every channel and
// emits a result for every channel but the soloed one, so busy stays high
// until the walk reaches the top channel. The last result of an item carries last.
// Items with an unknown kind or a channel at or beyond NUM_CHANNELS are
// dropped with no result. Reset returns faders and saves to 0, requested
// volumes to 127 and knobs and requested balances to 64.
`default_nettype none

module midi_channel_mixer
    import mcm_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  in_item_t  in_item,
    output logic      busy,
    output out_item_t result,
    output logic      result_valid
);

    mcm_cmd_t cmd;

    mcm_ctrl #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_item),
        .busy    (busy),
        .cmd     (cmd)
    );

    mcm_datapath #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (in_item),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mcm_ctrl.sv =====
// Sequencer for the mixer: accepts items and walks channels for solo.
`default_nettype none
`include "midi_channel_mixer_defines.svh"

module mcm_ctrl
    import mcm_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  in_item_t      in_item,
    output logic          busy,
    output mcm_cmd_t      cmd
);

    localparam logic [CHAN_W:0]   NUM_CH_L = (CHAN_W + 1)'(NUM_CHANNELS);
    localparam logic [CHAN_W-1:0] LAST_CH  = CHAN_W'(NUM_CHANNELS - 1);
    localparam logic [CHAN_W-1:0] PREV_CH  = CHAN_W'(NUM_CHANNELS - 2);

    typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_EMIT} state_t;

    state_t            state_reg, state_next;
    logic [CHAN_W-1:0] k_reg, k_next;
    logic [CHAN_W-1:0] ch_reg, ch_next;
    logic [KIND_W-1:0] op_reg, op_next;
    logic              on_reg, on_next;

    logic accept;
    logic item_ok;
    logic is_solo;
    logic last_emit;
    logic walk_done;

    assign accept  = start && (state_reg == ST_IDLE);
    assign item_ok = (in_item.kind <= KIND_BALANCE)
                     && ({1'b0, in_item.chan_index} < NUM_CH_L);
    assign is_solo = (op_reg == KIND_SOLO);
    assign last_emit = !is_solo || (k_reg == LAST_CH)
                       || ((k_reg == PREV_CH) && (ch_reg == LAST_CH));
    // solo still steps the soloed top channel after its last result
    assign walk_done = !is_solo || (k_reg == LAST_CH);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ch_next    = ch_reg;
        op_next    = op_reg;
        on_next    = on_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item_ok)
                begin
                    state_next = ST_STEP;
                    ch_next    = in_item.chan_index;
                    op_next    = in_item.kind;
                    on_next    = in_item.value[0];
                    k_next     = (in_item.kind == KIND_SOLO) ? '0 : in_item.chan_index;
                end
            end
            ST_STEP:
            begin
                if (is_solo && (k_reg == ch_reg))
                begin
                    if (k_reg == LAST_CH)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (walk_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_STEP;
                    k_next     = k_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            ch_reg    <= '0;
            op_reg    <= KIND_FADER;
            on_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            ch_reg    <= ch_next;
            op_reg    <= op_next;
            on_reg    <= on_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd.load      = accept;
        cmd.step      = (state_reg == ST_STEP);
        cmd.emit      = (state_reg == ST_EMIT);
        cmd.last      = last_emit;
        cmd.on        = on_reg;
        cmd.self_chan = (k_reg == ch_reg);
        cmd.op        = op_reg;
        cmd.idx       = k_reg;
    end

    `MCM_ASSERT_NEXT(a_accept_steps, accept && item_ok, state_reg == ST_STEP)
    `MCM_ASSERT_NEXT(a_last_ends, (state_reg == ST_EMIT) && walk_done, state_reg == ST_IDLE)
    `MCM_ASSERT_NOW(a_single_last, (state_reg == ST_EMIT) && !is_solo, last_emit)
    `MCM_ASSERT_NOW(a_solo_skip_self, (state_reg == ST_EMIT) && is_solo, k_reg != ch_reg)

endmodule

`default_nettype wire

// ===== rtl/core/mcm_datapath.sv =====
// Channel state registers, volume and balance weighting, result register.
`default_nettype none

module mcm_datapath
    import mcm_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  in_item_t  in_item,
    input  mcm_cmd_t  cmd,
    output out_item_t result,
    output logic      result_valid
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [VAL_W-1:0] fader_reg      [NUM_CHANNELS];
    logic [VAL_W-1:0] solo_save_reg  [NUM_CHANNELS];
    logic [VAL_W-1:0] mute_save_reg  [NUM_CHANNELS];
    logic [VAL_W-1:0] req_vol_reg    [NUM_CHANNELS];
    logic [VAL_W-1:0] knob_reg       [NUM_CHANNELS];
    logic [VAL_W-1:0] req_bal_reg    [NUM_CHANNELS];

    logic [VAL_W-1:0]   val_reg;
    logic [2*VAL_W-1:0] product_reg;
    logic [VAL_W:0]     sum_reg;
    logic               bal_sel_reg;
    logic [CHAN_W-1:0]  chan_reg;
    out_item_t          result_reg;
    logic               valid_reg;

    logic [IDX_W-1:0] a;
    logic [VAL_W-1:0] f_cur, ss_cur, ms_cur, rv_cur, kn_cur, rb_cur;
    logic [VAL_W-1:0] f_new, ss_new, ms_new, rv_new, kn_new, rb_new;

    logic [VAL_W-1:0] q0;
    logic [VAL_W:0]   rem;
    logic [VAL_W-1:0] vol_out;
    logic [VAL_W-1:0] bal_out;

    assign a      = cmd.idx[IDX_W-1:0];
    assign f_cur  = fader_reg[a];
    assign ss_cur = solo_save_reg[a];
    assign ms_cur = mute_save_reg[a];
    assign rv_cur = req_vol_reg[a];
    assign kn_cur = knob_reg[a];
    assign rb_cur = req_bal_reg[a];

    always_comb
    begin
        f_new  = f_cur;
        ss_new = ss_cur;
        ms_new = ms_cur;
        rv_new = rv_cur;
        kn_new = kn_cur;
        rb_new = rb_cur;
        unique case (cmd.op)
            KIND_FADER:   f_new  = val_reg;
            KIND_KNOB:    kn_new = val_reg;
            KIND_VOLUME:  rv_new = val_reg;
            KIND_BALANCE: rb_new = val_reg;
            KIND_MUTE:
            begin
                if (cmd.on)
                begin
                    ms_new = f_cur;
                    f_new  = FADER_OFF;
                end
                else
                begin
                    f_new = ms_cur;
                end
            end
            KIND_SOLO:
            begin
                if (cmd.on)
                begin
                    ss_new = f_cur;
                end
                if (!cmd.self_chan)
                begin
                    f_new = cmd.on ? FADER_OFF : ss_cur;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                fader_reg[i]     <= FADER_OFF;
                solo_save_reg[i] <= FADER_OFF;
                mute_save_reg[i] <= FADER_OFF;
                req_vol_reg[i]   <= VALUE_MAX;
                knob_reg[i]      <= VALUE_MID;
                req_bal_reg[i]   <= VALUE_MID;
            end
        end
        else if (cmd.step)
        begin
            fader_reg[a]     <= f_new;
            solo_save_reg[a] <= ss_new;
            mute_save_reg[a] <= ms_new;
            req_vol_reg[a]   <= rv_new;
            knob_reg[a]      <= kn_new;
            req_bal_reg[a]   <= rb_new;
        end
    end

    // floor(p / 127): p = 128*q0 + low, so p - 127*q0 = low + q0 < 254
    assign q0      = product_reg[2*VAL_W-1:VAL_W];
    assign rem     = {1'b0, product_reg[VAL_W-1:0]} + {1'b0, q0};
    assign vol_out = (rem >= {1'b0, VALUE_MAX}) ? q0 + 1'b1 : q0;

    always_comb
    begin
        priority if (sum_reg < {1'b0, VALUE_MID})
        begin
            bal_out = '0;
        end
        else if (sum_reg > ({1'b0, VALUE_MAX} + {1'b0, VALUE_MID}))
        begin
            bal_out = VALUE_MAX;
        end
        else
        begin
            bal_out = VAL_W'(sum_reg - {1'b0, VALUE_MID});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= in_item.value;
        end
        if (cmd.step)
        begin
            product_reg <= f_new * rv_new;
            sum_reg     <= {1'b0, kn_new} + {1'b0, rb_new};
            bal_sel_reg <= (cmd.op == KIND_KNOB) || (cmd.op == KIND_BALANCE);
            chan_reg    <= cmd.idx;
        end
        if (cmd.emit)
        begin
            result_reg.out_chan   <= chan_reg;
            result_reg.is_balance <= bal_sel_reg;
            result_reg.out_value  <= bal_sel_reg ? bal_out : vol_out;
            result_reg.last       <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

`default_nettype wire
